FILE: src/tdt_pkg.sv
// Shared constants, types and helper functions of the turn-drive-turn controller.
`timescale 1ns / 1ps
`default_nettype none
package tdt_pkg;

   localparam int CORDIC_STEPS = 16;
   localparam int CORDIC_RUN   = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
   localparam int CNT_W        = 5;

   localparam int XW = 37;
   localparam int ZW = 28;
   localparam int EW = 18;
   localparam int MA_W = 36;
   localparam int MB_W = 16;
   localparam int MP_W = MA_W + MB_W;
   localparam int RHO_W = 27;

   localparam logic signed [ZW-1:0] HALF_PI_Q24 = 28'sd26353589;
   localparam logic signed [EW-1:0] PI_Q13      = 18'sd25736;
   localparam logic signed [EW-1:0] TWO_PI_Q13  = 18'sd51472;
   localparam logic [MB_W-1:0]      MAG_GAIN    = 16'd39797;

   localparam logic [1:0] OP_GOAL = 2'd0;
   localparam logic [1:0] OP_POSE = 2'd1;
   localparam logic [1:0] OP_KEY  = 2'd2;

   localparam logic [7:0] KEY_GO     = 8'd103;
   localparam logic [7:0] KEY_RELOAD = 8'd114;

   localparam logic REQ_RELOAD = 1'b0;
   localparam logic REQ_NEXT   = 1'b1;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 23;
   localparam logic [CSR_IDX_W-1:0] CSR_DRIVE_GAIN  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STEER_GAIN  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FINAL_GAIN  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_LINEAR  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_TURN    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_ARRIVE_DIST = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_ALIGNED     = 3'd6;

   typedef enum logic [1:0] {
      MODE_STOP  = 2'd0,
      MODE_TURN  = 2'd1,
      MODE_DRIVE = 2'd2,
      MODE_FINAL = 2'd3
   } mode_type;

   // arctangent of 2^-i in units of 2^-24 rad
   function automatic logic [23:0] atan_entry(input logic [CNT_W-1:0] i);
      logic [23:0] r;
      case (i)
         5'd0:  r = 24'd13176795;
         5'd1:  r = 24'd7778716;
         5'd2:  r = 24'd4110060;
         5'd3:  r = 24'd2086331;
         5'd4:  r = 24'd1047214;
         5'd5:  r = 24'd524117;
         5'd6:  r = 24'd262123;
         5'd7:  r = 24'd131069;
         5'd8:  r = 24'd65536;
         5'd9:  r = 24'd32768;
         5'd10: r = 24'd16384;
         5'd11: r = 24'd8192;
         5'd12: r = 24'd4096;
         5'd13: r = 24'd2048;
         5'd14: r = 24'd1024;
         5'd15: r = 24'd512;
         5'd16: r = 24'd256;
         5'd17: r = 24'd128;
         5'd18: r = 24'd64;
         5'd19: r = 24'd32;
         5'd20: r = 24'd16;
         5'd21: r = 24'd8;
         5'd22: r = 24'd4;
         5'd23: r = 24'd2;
         default: r = 24'd0;
      endcase
      return r;
   endfunction

   // fold into [-pi, pi]; one pass covers inputs within [-3pi, 3pi]
   function automatic logic signed [EW-1:0] wrap_angle(input logic signed [EW-1:0] a);
      logic signed [EW-1:0] r;
      if (a > PI_Q13) begin
         r = a - TWO_PI_Q13;
      end else if (a < -PI_Q13) begin
         r = a + TWO_PI_Q13;
      end else begin
         r = a;
      end
      return r;
   endfunction

endpackage
`default_nettype wire

FILE: src/tdt_if.sv
// Handshake channel interfaces: pose/key requests, responses and register writes.
`timescale 1ns / 1ps
`default_nettype none
interface tdt_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  operation;
   logic [23:0] pos_x;
   logic [23:0] pos_y;
   logic [15:0] heading;
   logic [7:0]  key_code;
   modport source (output valid, operation, pos_x, pos_y, heading, key_code, input ready);
   modport sink (input valid, operation, pos_x, pos_y, heading, key_code, output ready);
endinterface

interface tdt_rsp_if;
   logic        valid;
   logic        ready;
   logic        vel_valid;
   logic [22:0] linear_speed;
   logic [15:0] turn_speed;
   logic        request_valid;
   logic        request_code;
   logic [1:0]  mode;
   modport source (output valid, vel_valid, linear_speed, turn_speed, request_valid,
                   request_code, mode, input ready);
   modport sink (input valid, vel_valid, linear_speed, turn_speed, request_valid,
                 request_code, mode, output ready);
endinterface

interface tdt_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [22:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: src/tdt_cordic.sv
// Iterative vectoring CORDIC: one micro-rotation per cycle through shared shifters.
`timescale 1ns / 1ps
`default_nettype none
module tdt_cordic (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic signed [24:0]            dx,
   input  wire logic signed [24:0]            dy,
   output logic                               done,
   output logic signed [tdt_pkg::XW-1:0]      x_out,
   output logic signed [tdt_pkg::ZW-1:0]      z_out
);
   import tdt_pkg::*;

   logic signed [XW-1:0] x_ff, y_ff, xs, ys, x_in, y_in;
   logic signed [XW-1:0] x0, y0;
   logic signed [ZW-1:0] z_ff, z_in, at;
   logic [CNT_W-1:0]     cnt_ff;
   logic                 busy_ff, done_ff;

   assign x0 = {{(XW-33){dx[24]}}, dx, 8'b0};
   assign y0 = {{(XW-33){dy[24]}}, dy, 8'b0};
   assign xs = x_ff >>> cnt_ff;
   assign ys = y_ff >>> cnt_ff;
   assign at = {{(ZW-24){1'b0}}, atan_entry(cnt_ff)};

   always_comb begin
      if (y_ff < 0) begin
         x_in = x_ff - ys;
         y_in = y_ff + xs;
         z_in = z_ff - at;
      end else begin
         x_in = x_ff + ys;
         y_in = y_ff - xs;
         z_in = z_ff + at;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(CORDIC_RUN - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         // pre-rotate the left half-plane by a quarter turn
         if (x0 < 0) begin
            if (y0 >= 0) begin
               x_ff <= y0;
               y_ff <= -x0;
               z_ff <= HALF_PI_Q24;
            end else begin
               x_ff <= -y0;
               y_ff <= x0;
               z_ff <= -HALF_PI_Q24;
            end
         end else begin
            x_ff <= x0;
            y_ff <= y0;
            z_ff <= '0;
         end
      end else if (busy_ff) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
      end
   end

   assign done  = done_ff;
   assign x_out = x_ff;
   assign z_out = z_ff;

endmodule
`default_nettype wire

FILE: src/turn_drive_turn_pose_controller.sv
// Turn-drive-turn go-to-goal controller top level: sequencer, shared multiplier, registers.
// Use: req_chan carries goal poses (operation 0), pose samples (1) and key events (2).
// Every accepted request beat yields exactly one rsp_chan beat with the held velocity
// command, an optional pose request and the mode after the item.
// csr_chan writes the seven gain and limit registers; it is always ready.
// Goal, key, stopped-pose and unused-operation items go straight to the response; a
// final-turn pose checks the alignment and, unless aligned, runs the shared multiplier
// once. A turn or drive pose runs the vectoring CORDIC (one step a cycle, 16 steps) and
// the shared 36x16 multiplier up to three times: the magnitude, then in turn mode the turn
// speed unless aligned, or in drive mode the linear and turn speeds unless arriving; a
// pose on the goal itself skips the CORDIC.
// req_chan.ready is high only while idle, so one item is in flight at a time; the next
// item is taken the cycle after its response beat is accepted.
// The response is held in registers while rsp_chan.ready is low.
// Reset (synchronous, active high) returns the registers to their defaults, clears the
// goal and held speeds, and puts the controller in the stop mode.
`timescale 1ns / 1ps
`default_nettype none
module turn_drive_turn_pose_controller (
   input wire logic clock,
   input wire logic reset,
   tdt_req_if.sink  req_chan,
   tdt_rsp_if.source rsp_chan,
   tdt_csr_if.sink  csr_chan
);
   import tdt_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_CORD, S_MAG, S_RHO, S_LMUL, S_LIN, S_FCHK, S_TMUL, S_TURN, S_OUT
   } state_type;

   state_type state_ff;

   logic [15:0] drive_gain_ff, steer_gain_ff, final_gain_ff;
   logic [22:0] max_lin_ff, arrive_ff;
   logic [14:0] max_turn_ff, aligned_ff;

   mode_type          mode_ff;
   logic [23:0]       goal_x_ff, goal_y_ff;
   logic [15:0]       goal_h_ff;
   logic [22:0]       held_lin_ff;
   logic signed [15:0] held_turn_ff;
   logic              vel_valid_ff, req_valid_ff, req_code_ff;

   logic signed [EW-1:0] err_ff;
   logic [15:0]          ph_ff;
   logic [MA_W-1:0]      mul_a_ff;
   logic [MB_W-1:0]      mul_b_ff;
   logic [MP_W-1:0]      prod_ff;

   logic               accept;
   logic signed [24:0] dx, dy;
   logic               zero_vec;
   logic               cord_start, cord_done;
   logic signed [XW-1:0] cord_x;
   logic signed [ZW-1:0] cord_z;
   logic signed [ZW-1:0] z_rnd;
   logic signed [EW-1:0] ang;
   logic [MP_W:0]        rho_sum;
   logic [14:0]          abs_e;
   logic                 aligned;
   logic [14:0]          turn_mag;
   logic [22:0]          lin_cl;
   logic [MP_W-13:0]     prod_sh;

   assign accept = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == S_IDLE);
   assign csr_chan.ready = 1'b1;

   assign dx = $signed({goal_x_ff[23], goal_x_ff}) - $signed({req_chan.pos_x[23], req_chan.pos_x});
   assign dy = $signed({goal_y_ff[23], goal_y_ff}) - $signed({req_chan.pos_y[23], req_chan.pos_y});
   assign zero_vec = (dx == '0) && (dy == '0);
   assign cord_start = accept && (req_chan.operation == OP_POSE) &&
                       ((mode_ff == MODE_TURN) || (mode_ff == MODE_DRIVE)) && !zero_vec;

   tdt_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .start (cord_start),
      .dx    (dx),
      .dy    (dy),
      .done  (cord_done),
      .x_out (cord_x),
      .z_out (cord_z)
   );

   // Q24 angle to Q13 with rounding
   assign z_rnd   = cord_z + ZW'(1024);
   assign ang     = EW'(z_rnd >>> 11);
   assign rho_sum = {1'b0, prod_ff} + (MP_W+1)'(1 << 23);
   assign abs_e   = err_ff[EW-1] ? 15'(-err_ff) : err_ff[14:0];
   assign aligned = abs_e < aligned_ff;
   assign prod_sh = prod_ff[MP_W-1:12];
   assign turn_mag = (prod_sh > (MP_W-12)'(max_turn_ff)) ? max_turn_ff : prod_sh[14:0];
   assign lin_cl   = (prod_sh > (MP_W-12)'(max_lin_ff)) ? max_lin_ff : prod_sh[22:0];

   // shared multiplier, one registered product a cycle
   always_ff @(posedge clock) begin
      prod_ff <= {{MB_W{1'b0}}, mul_a_ff} * {{MA_W{1'b0}}, mul_b_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         drive_gain_ff <= 16'd3072;
         steer_gain_ff <= 16'd4096;
         final_gain_ff <= 16'd4096;
         max_lin_ff    <= 23'd19200;
         max_turn_ff   <= 15'd3277;
         arrive_ff     <= 23'd1280;
         aligned_ff    <= 15'd246;
         mode_ff       <= MODE_STOP;
         goal_x_ff     <= '0;
         goal_y_ff     <= '0;
         goal_h_ff     <= '0;
         held_lin_ff   <= '0;
         held_turn_ff  <= '0;
         vel_valid_ff  <= 1'b0;
         req_valid_ff  <= 1'b0;
         req_code_ff   <= REQ_RELOAD;
      end else begin
         if (csr_chan.valid) begin
            case (csr_chan.index)
               CSR_DRIVE_GAIN:  drive_gain_ff <= csr_chan.data[15:0];
               CSR_STEER_GAIN:  steer_gain_ff <= csr_chan.data[15:0];
               CSR_FINAL_GAIN:  final_gain_ff <= csr_chan.data[15:0];
               CSR_MAX_LINEAR:  max_lin_ff    <= csr_chan.data;
               CSR_MAX_TURN:    max_turn_ff   <= csr_chan.data[14:0];
               CSR_ARRIVE_DIST: arrive_ff     <= csr_chan.data;
               CSR_ALIGNED:     aligned_ff    <= csr_chan.data[14:0];
               default: ;
            endcase
         end

         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  ph_ff        <= req_chan.heading;
                  vel_valid_ff <= 1'b0;
                  req_valid_ff <= 1'b0;
                  req_code_ff  <= REQ_RELOAD;
                  state_ff     <= S_OUT;
                  case (req_chan.operation)
                     OP_GOAL: begin
                        goal_x_ff <= req_chan.pos_x;
                        goal_y_ff <= req_chan.pos_y;
                        goal_h_ff <= req_chan.heading;
                        mode_ff   <= MODE_TURN;
                     end
                     OP_POSE: begin
                        vel_valid_ff <= 1'b1;
                        case (mode_ff)
                           MODE_TURN, MODE_DRIVE: begin
                              if (zero_vec) begin
                                 mul_a_ff <= '0;
                                 mul_b_ff <= MAG_GAIN;
                                 err_ff   <= wrap_angle(-$signed({{2{req_chan.heading[15]}},
                                                                   req_chan.heading}));
                                 state_ff <= S_MAG;
                              end else begin
                                 state_ff <= S_CORD;
                              end
                           end
                           MODE_FINAL: begin
                              err_ff <= wrap_angle($signed({{2{goal_h_ff[15]}}, goal_h_ff}) -
                                                   $signed({{2{req_chan.heading[15]}},
                                                            req_chan.heading}));
                              state_ff <= S_FCHK;
                           end
                           default: begin
                              held_lin_ff  <= '0;
                              held_turn_ff <= '0;
                           end
                        endcase
                     end
                     OP_KEY: begin
                        if (req_chan.key_code == KEY_GO) begin
                           mode_ff <= MODE_TURN;
                        end else begin
                           if (req_chan.key_code == KEY_RELOAD) begin
                              req_valid_ff <= 1'b1;
                              req_code_ff  <= REQ_RELOAD;
                           end
                           mode_ff      <= MODE_STOP;
                           held_lin_ff  <= '0;
                           held_turn_ff <= '0;
                           vel_valid_ff <= 1'b1;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            S_CORD: begin
               if (cord_done) begin
                  mul_a_ff <= cord_x[MA_W-1:0];
                  mul_b_ff <= MAG_GAIN;
                  err_ff   <= wrap_angle(ang - $signed({{2{ph_ff[15]}}, ph_ff}));
                  state_ff <= S_MAG;
               end
            end
            S_MAG: begin
               state_ff <= S_RHO;
            end
            S_RHO: begin
               if (mode_ff == MODE_TURN) begin
                  if (aligned) begin
                     mode_ff      <= MODE_DRIVE;
                     held_turn_ff <= '0;
                     state_ff     <= S_OUT;
                  end else begin
                     mul_a_ff <= MA_W'(abs_e);
                     mul_b_ff <= steer_gain_ff;
                     state_ff <= S_TMUL;
                  end
               end else begin
                  if (rho_sum[24 +: RHO_W] < RHO_W'(arrive_ff)) begin
                     mode_ff      <= MODE_FINAL;
                     held_lin_ff  <= '0;
                     held_turn_ff <= '0;
                     state_ff     <= S_OUT;
                  end else begin
                     mul_a_ff <= MA_W'(rho_sum[24 +: RHO_W]);
                     mul_b_ff <= drive_gain_ff;
                     state_ff <= S_LMUL;
                  end
               end
            end
            S_LMUL: begin
               state_ff <= S_LIN;
            end
            S_LIN: begin
               held_lin_ff <= lin_cl;
               mul_a_ff    <= MA_W'(abs_e);
               mul_b_ff    <= steer_gain_ff;
               state_ff    <= S_TMUL;
            end
            S_FCHK: begin
               if (aligned) begin
                  mode_ff      <= MODE_STOP;
                  held_turn_ff <= '0;
                  req_valid_ff <= 1'b1;
                  req_code_ff  <= REQ_NEXT;
                  state_ff     <= S_OUT;
               end else begin
                  mul_a_ff <= MA_W'(abs_e);
                  mul_b_ff <= final_gain_ff;
                  state_ff <= S_TMUL;
               end
            end
            S_TMUL: begin
               state_ff <= S_TURN;
            end
            S_TURN: begin
               held_turn_ff <= err_ff[EW-1] ? -$signed({1'b0, turn_mag})
                                            : $signed({1'b0, turn_mag});
               state_ff     <= S_OUT;
            end
            S_OUT: begin
               // hold the beat until taken
               if (rsp_chan.ready) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_chan.valid         = (state_ff == S_OUT);
   assign rsp_chan.vel_valid     = vel_valid_ff;
   assign rsp_chan.linear_speed  = held_lin_ff;
   assign rsp_chan.turn_speed    = held_turn_ff;
   assign rsp_chan.request_valid = req_valid_ff;
   assign rsp_chan.request_code  = req_code_ff;
   assign rsp_chan.mode          = mode_ff;

endmodule
`default_nettype wire
